// File: rtl/skct_pkg.sv
package skct_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int GRP_SIZE    = 8;
   localparam int GRP_NUM     = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_UPDATE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EXISTS    = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic signed [31:0]  part_key;
      logic signed [31:0]  quantity;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic signed [31:0]  on_hand;
   } rsp_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_CMP,
      FSM_GRP,
      FSM_SEL,
      FSM_EXE
   } fsm_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic group;
      logic select;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

// File: rtl/skct_ctrl.sv
module skct_ctrl import skct_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   fsm_type state_ff;
   fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = FSM_CMP;
            end
         end
         FSM_CMP:  state_in = FSM_GRP;
         FSM_GRP:  state_in = FSM_SEL;
         FSM_SEL:  state_in = FSM_EXE;
         FSM_EXE: begin
            if (stat.out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default:  state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         FSM_CMP:  cmd.compare = 1'b1;
         FSM_GRP:  cmd.group   = 1'b1;
         FSM_SEL:  cmd.select  = 1'b1;
         FSM_EXE:  cmd.exec    = stat.out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // The result stage must have room before the table is touched.
   a_exe_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_EXE && !stat.out_free) |=> (state_ff == FSM_EXE))
      else $error("execute state left while result register was busy");

endmodule

// File: rtl/skct_dp.sv
module skct_dp import skct_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   req_type                   req_ff;
   logic signed [31:0]        key_store_ff [TABLE_DEPTH];
   logic signed [31:0]        qty_store_ff [TABLE_DEPTH];
   logic [CNT_W-1:0]          count_ff;
   logic [TABLE_DEPTH-1:0]    lt_ff;
   logic [TABLE_DEPTH-1:0]    eq_ff;
   logic [TABLE_DEPTH-1:0]    lt_prev;
   logic [31:0]               grp_qty_ff [GRP_NUM];
   logic [31:0]               grp_qty_in [GRP_NUM];
   logic                      found_ff;
   logic signed [31:0]        sel_qty_ff;
   logic [31:0]               sel_qty_in;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;
   rsp_type                   rsp_data_in;
   logic signed [32:0]        sum_wide;
   logic signed [31:0]        sum_sat;
   logic                      ins_do;
   logic                      upd_do;
   logic                      fire;
   logic                      full;

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign fire          = cmd.exec;
   assign full          = (count_ff == CNT_W'(TABLE_DEPTH));

   // Cell j is the insertion point when it is not below the key and its
   // lower neighbor is (or it is the bottom cell).
   assign lt_prev = {lt_ff[TABLE_DEPTH-2:0], 1'b1};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Stage one: every cell compares its key with the request key.
   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         for (int j = 0; j < TABLE_DEPTH; j++) begin
            lt_ff[j] <= (CNT_W'(j) < count_ff) && (key_store_ff[j] < req_ff.part_key);
            eq_ff[j] <= (CNT_W'(j) < count_ff) && (key_store_ff[j] == req_ff.part_key);
         end
      end
   end

   // Stage two: quantity of the matching cell within each group.
   always_comb begin
      for (int g = 0; g < GRP_NUM; g++) begin
         grp_qty_in[g] = '0;
         for (int k = 0; k < GRP_SIZE; k++) begin
            if (g * GRP_SIZE + k < TABLE_DEPTH) begin
               if (eq_ff[g * GRP_SIZE + k]) begin
                  grp_qty_in[g] = grp_qty_in[g] | qty_store_ff[g * GRP_SIZE + k];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.group) begin
         grp_qty_ff <= grp_qty_in;
         found_ff   <= |eq_ff;
      end
   end

   // Stage three: merge the groups.
   always_comb begin
      sel_qty_in = '0;
      for (int g = 0; g < GRP_NUM; g++) begin
         sel_qty_in = sel_qty_in | grp_qty_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.select) begin
         sel_qty_ff <= sel_qty_in;
      end
   end

   // Stage four: decide, write the table and load the result register.
   assign sum_wide = {sel_qty_ff[31], sel_qty_ff} + {req_ff.quantity[31], req_ff.quantity};

   always_comb begin
      if (sum_wide[32] != sum_wide[31]) begin
         sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sum_sat = sum_wide[31:0];
      end
   end

   always_comb begin
      ins_do              = 1'b0;
      upd_do              = 1'b0;
      rsp_data_in.status  = ST_NOT_FOUND;
      rsp_data_in.on_hand = '0;
      case (req_ff.opcode)
         OP_INSERT: begin
            if (full) begin
               rsp_data_in.status = ST_FULL;
            end else if (found_ff) begin
               rsp_data_in.status = ST_EXISTS;
            end else begin
               rsp_data_in.status  = ST_OK;
               rsp_data_in.on_hand = req_ff.quantity;
               ins_do              = fire;
            end
         end
         OP_SEARCH: begin
            if (found_ff) begin
               rsp_data_in.status  = ST_OK;
               rsp_data_in.on_hand = sel_qty_ff;
            end
         end
         OP_UPDATE: begin
            if (found_ff) begin
               rsp_data_in.status  = ST_OK;
               rsp_data_in.on_hand = sum_sat;
               upd_do              = fire;
            end
         end
         default: begin
            rsp_data_in.status = ST_NOT_FOUND;
         end
      endcase
   end

   for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
      always_ff @(posedge clock) begin
         if (ins_do && !lt_ff[j]) begin
            if (lt_prev[j]) begin
               key_store_ff[j] <= req_ff.part_key;
               qty_store_ff[j] <= req_ff.quantity;
            end else if (j > 0) begin
               key_store_ff[j] <= key_store_ff[(j > 0) ? j - 1 : 0];
               qty_store_ff[j] <= qty_store_ff[(j > 0) ? j - 1 : 0];
            end
         end else if (upd_do && eq_ff[j]) begin
            qty_store_ff[j] <= sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ins_do) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("entry count moved by other than one");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire))
      else $error("result appeared without an executed item");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      ins_do |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the table");

endmodule

// File: rtl/sorted_key_count_table.sv
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   req_data  (opcode, part_key, quantity)
// rsp       out        rsp_valid / rsp_ready   rsp_data  (status, on_hand)
//
// An item is accepted in the idle state and its result is registered after
// a compare step in which every table cell checks its key, a group step and
// a select step that pick the matching quantity through a two-level group
// tree, and an execute step that adds, shifts the cells for an insert and
// loads the result register.
// The next item can be accepted while a result still waits in rsp_data;
// a stalled result only holds the execute cycle until the register frees.
// Reset empties the table by clearing the entry count; no clearing pass runs.
module sorted_key_count_table import skct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Sequencing commands from the controller and result-stage status back.
   cmd_type  cmd;
   stat_type stat;

   // The controller steps each item through compare, group, select and execute.
   skct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds the sorted row of cells and the result register.
   skct_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
